// ===== hw/rtl/epd_pkg.sv =====
// Shared types and constants for the e-paper pixel drive generator.
// Used by epd_drive_encode and epd_pixel_drive_waveform; depends on nothing else.
`timescale 1ns / 1ps

package epd_pkg;

   // Field widths of the request, response and state word.
   localparam int PIX_W      = 8;
   localparam int GROUP_W    = 15;
   localparam int DRIVE_W    = 8;
   localparam int WORD_W     = 32;
   localparam int PAIR_W     = 8;
   localparam int PAIRS      = WORD_W / PAIR_W;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 2;

   // Register indexes on the csr port.
   localparam logic [CSR_IDX_W-1:0] CSR_MODE           = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_TO_WHITE = 1'b1;

   // Operating modes; the unused code behaves as idle.
   localparam logic [1:0] MODE_IDLE  = 2'd0;
   localparam logic [1:0] MODE_IMAGE = 2'd1;
   localparam logic [1:0] MODE_VIDEO = 2'd2;

   // Source-driver codes.
   localparam logic [1:0] DRV_NONE = 2'b00;
   localparam logic [1:0] DRV_POS  = 2'b01;
   localparam logic [1:0] DRV_NEG  = 2'b10;

   // Pair state byte: [7:5] first counter, [4:2] second counter, [1] first colour,
   // [0] second colour. The mask keeps the counters of pixels whose colour held.
   localparam logic [PAIR_W-1:0] KEEP_ON_CHANGE [4] = '{8'hfc, 8'he0, 8'h1c, 8'h00};
   localparam logic [PAIR_W-1:0] CNT_A_SAT = 8'h80;
   localparam logic [PAIR_W-1:0] CNT_B_SAT = 8'h10;
   localparam logic [PAIR_W-1:0] STEP_MASK = 8'h24;
   localparam logic [2:0]        CNT_MAX   = 3'd4;

   typedef struct packed {
      logic [1:0] mode;
      logic       image_to_white;
   } cfg_type;

   typedef struct packed {
      logic [DRIVE_W-1:0] first_drive;
      logic [DRIVE_W-1:0] second_drive;
      logic [WORD_W-1:0]  next_word;
      logic               state_we;
   } drive_type;

endpackage

// ===== hw/rtl/epd_pixel_drive_waveform.sv =====
// Top level of the e-paper pixel drive generator: index pipeline, state memory, output.
// Depends on epd_pkg and epd_drive_encode.
`timescale 1ns / 1ps

// Usage:
// Each req beat carries one frame-buffer byte (eight one-bit pixels, first pixel in
// bit 7) and its group index; each rsp beat carries the two source-driver bytes for
// it, one rsp beat per req beat, in order. The csr port sets mode and image_to_white
// and must only be written while no beat is in flight.
// Throughput is one beat per cycle unless rsp_ready is low or the state clear is running.
// The group index is reduced modulo STATE_GROUPS in three stages (reciprocal multiply,
// back-multiply and subtract, one correction), the state word is read from the memory
// in the fourth, and the codes and new state are formed in the fifth.
// Back-to-back beats to the same group are served from a write-back bypass register.
// After reset the state memory is cleared one word per cycle; req_ready stays low
// until it is done, while csr writes are taken at once. When rsp_ready is low with a
// beat in the output register, that beat holds, the other beats move on only into
// empty stages, and req_ready drops once the pipeline is full.

module epd_pixel_drive_waveform
   import epd_pkg::*;
#(
   parameter int unsigned STATE_GROUPS = 32768
)(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [PIX_W-1:0]      req_pixel_byte,
   input  logic [GROUP_W-1:0]    req_group_index,

   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [DRIVE_W-1:0]    rsp_first_drive_byte,
   output logic [DRIVE_W-1:0]    rsp_second_drive_byte,

   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int unsigned IDX_W      = (STATE_GROUPS > 1) ? $clog2(STATE_GROUPS) : 1;
   localparam int unsigned CALC_W     = ((IDX_W > GROUP_W) ? IDX_W : GROUP_W) + 1;
   localparam int unsigned GROUP_SPAN = 1 << GROUP_W;
   localparam int unsigned RECIP_VAL  =
      (STATE_GROUPS <= GROUP_SPAN) ? GROUP_SPAN / STATE_GROUPS : 0;
   localparam int unsigned PROD_W     = 2*GROUP_W + 1;

   localparam logic [GROUP_W:0]   RECIP       = (GROUP_W+1)'(RECIP_VAL);
   localparam logic [GROUP_W-1:0] GROUPS_LO   = GROUP_W'(STATE_GROUPS);
   localparam logic [CALC_W-1:0]  GROUPS_FULL = CALC_W'(STATE_GROUPS);
   localparam logic [IDX_W-1:0]   LAST_IDX    = IDX_W'(STATE_GROUPS - 1);

   // Configuration registers.
   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode           <= MODE_IDLE;
         cfg_ff.image_to_white <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MODE:           cfg_ff.mode           <= csr_wdata;
            CSR_IMAGE_TO_WHITE: cfg_ff.image_to_white <= csr_wdata[0];
         endcase
      end
   end

   // Stall control: a stage loads when it is empty or its beat moves on.
   logic a_valid_ff, b_valid_ff, c_valid_ff, d_valid_ff, rsp_valid_ff;
   logic en_a, en_b, en_c, en_d, en_e;
   logic clr_busy_ff;

   assign en_e      = !rsp_valid_ff || rsp_ready;
   assign en_d      = !d_valid_ff   || en_e;
   assign en_c      = !c_valid_ff   || en_d;
   assign en_b      = !b_valid_ff   || en_c;
   assign en_a      = !a_valid_ff   || en_b;
   assign req_ready = en_a && !clr_busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         d_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en_a) a_valid_ff   <= req_valid && req_ready;
         if (en_b) b_valid_ff   <= a_valid_ff;
         if (en_c) c_valid_ff   <= b_valid_ff;
         if (en_d) d_valid_ff   <= c_valid_ff;
         if (en_e) rsp_valid_ff <= d_valid_ff;
      end
   end

   // Stage A: estimate the quotient by a reciprocal multiply (low by at most one).
   logic [PROD_W-1:0]  quot_prod;
   logic [GROUP_W-1:0] a_quot_in, a_quot_ff, a_group_ff;
   logic [PIX_W-1:0]   a_pix_ff;

   assign quot_prod = PROD_W'(req_group_index) * PROD_W'(RECIP);
   assign a_quot_in = quot_prod[2*GROUP_W-1:GROUP_W];

   always_ff @(posedge clock) begin
      if (en_a) begin
         a_pix_ff   <= req_pixel_byte;
         a_group_ff <= req_group_index;
         a_quot_ff  <= a_quot_in;
      end
   end

   // Stage B: partial remainder, below twice the group count.
   logic [GROUP_W-1:0] b_rem_in, b_rem_ff;
   logic [PIX_W-1:0]   b_pix_ff;

   assign b_rem_in = a_group_ff - a_quot_ff * GROUPS_LO;

   always_ff @(posedge clock) begin
      if (en_b) begin
         b_pix_ff <= a_pix_ff;
         b_rem_ff <= b_rem_in;
      end
   end

   // Stage C: one correcting subtract gives the state address.
   logic [CALC_W-1:0] rem_wide, rem_fix;
   logic [IDX_W-1:0]  c_addr_in, c_addr_ff;
   logic [PIX_W-1:0]  c_pix_ff;

   assign rem_wide  = CALC_W'(b_rem_ff);
   assign rem_fix   = (rem_wide >= GROUPS_FULL) ? rem_wide - GROUPS_FULL : rem_wide;
   assign c_addr_in = rem_fix[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (en_c) begin
         c_pix_ff  <= b_pix_ff;
         c_addr_ff <= c_addr_in;
      end
   end

   // Stage D: state memory read; the word lands with its beat.
   logic [WORD_W-1:0] state_mem [STATE_GROUPS];
   logic [WORD_W-1:0] mem_rdata_ff;
   logic [IDX_W-1:0]  d_addr_ff;
   logic [PIX_W-1:0]  d_pix_ff;

   always_ff @(posedge clock) begin
      if (en_d) begin
         d_pix_ff     <= c_pix_ff;
         d_addr_ff    <= c_addr_ff;
         mem_rdata_ff <= state_mem[c_addr_ff];
      end
   end

   // The most recent write holds the newest value of its address, so it
   // overrides a read that raced with it.
   logic              wb_valid_ff;
   logic [IDX_W-1:0]  wb_addr_ff;
   logic [WORD_W-1:0] wb_data_ff;
   logic [WORD_W-1:0] state_word;

   assign state_word = (wb_valid_ff && wb_addr_ff == d_addr_ff) ? wb_data_ff : mem_rdata_ff;

   // Drive codes and next state.
   drive_type drive;

   epd_drive_encode u_encode (
      .cfg        (cfg_ff),
      .pixel_byte (d_pix_ff),
      .state_word (state_word),
      .drive      (drive)
   );

   // Write port: the clear pass after reset, then the beat leaving stage D.
   logic              item_we, mem_we;
   logic [IDX_W-1:0]  mem_waddr;
   logic [WORD_W-1:0] mem_wdata;
   logic [IDX_W-1:0]  clr_addr_ff;

   assign item_we   = d_valid_ff && en_e && drive.state_we;
   assign mem_we    = clr_busy_ff || item_we;
   assign mem_waddr = clr_busy_ff ? clr_addr_ff : d_addr_ff;
   assign mem_wdata = clr_busy_ff ? '0 : drive.next_word;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         state_mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         if (clr_addr_ff == LAST_IDX) begin
            clr_busy_ff <= 1'b0;
         end else begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wb_valid_ff <= 1'b0;
      end else if (item_we) begin
         wb_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (item_we) begin
         wb_addr_ff <= d_addr_ff;
         wb_data_ff <= drive.next_word;
      end
   end

   // Stage E: output register.
   logic [DRIVE_W-1:0] rsp_first_ff, rsp_second_ff;

   always_ff @(posedge clock) begin
      if (en_e) begin
         rsp_first_ff  <= drive.first_drive;
         rsp_second_ff <= drive.second_drive;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_first_drive_byte  = rsp_first_ff;
   assign rsp_second_drive_byte = rsp_second_ff;

   // Every counter written back stays at or below its saturation value.
   logic counters_ok;

   always_comb begin
      counters_ok = 1'b1;
      for (int p = 0; p < PAIRS; p++) begin
         if (mem_wdata[PAIR_W*p+5 +: 3] > CNT_MAX || mem_wdata[PAIR_W*p+2 +: 3] > CNT_MAX) begin
            counters_ok = 1'b0;
         end
      end
   end

   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> !(a_valid_ff || b_valid_ff || c_valid_ff || d_valid_ff || rsp_valid_ff))
      else $error("A beat is in the pipeline during the state clear.");

   a_counter_sat: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> counters_ok)
      else $error("A state counter was written above its saturation value.");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(d_valid_ff))
      else $error("The output register loaded without a beat in the read stage.");

endmodule

// ===== hw/rtl/epd_drive_encode.sv =====
// Drive-code encoder: image, video and idle modes for one pixel byte.
// Depends on epd_pkg; purely combinational, used by epd_pixel_drive_waveform.
`timescale 1ns / 1ps

module epd_drive_encode
   import epd_pkg::*;
(
   input  cfg_type             cfg,
   input  logic [PIX_W-1:0]    pixel_byte,
   input  logic [WORD_W-1:0]   state_word,
   output drive_type           drive
);

   logic [2*PIX_W-1:0] image_codes;
   logic [2*PIX_W-1:0] video_codes;
   logic [WORD_W-1:0]  video_word;

   // Image mode: every set pixel gets the one configured code.
   always_comb begin
      for (int k = 0; k < PIX_W; k++) begin
         image_codes[2*k +: 2] = pixel_byte[k] ?
            (cfg.image_to_white ? DRV_NEG : DRV_POS) : DRV_NONE;
      end
   end

   // Video mode: one lane per pixel pair, each with two saturating counters.
   for (genvar p = 0; p < PAIRS; p++) begin : g_pair
      logic [PAIR_W-1:0] st_old;
      logic [PAIR_W-1:0] st_mix;
      logic [PAIR_W-1:0] st_new;
      logic [1:0]        dir;
      logic [3:0]        nib;

      assign st_old = state_word[PAIR_W*p +: PAIR_W];
      assign dir    = pixel_byte[PIX_W-2-2*p +: 2];

      // A changed colour restarts its counter; the new colours are stored.
      assign st_mix = (st_old & KEEP_ON_CHANGE[st_old[1:0] ^ dir]) | {6'd0, dir};

      // Drive while the counter is below its limit.
      assign nib[3:2] = ((st_mix & CNT_A_SAT) != '0) ? DRV_NONE :
                        (dir[1] ? DRV_POS : DRV_NEG);
      assign nib[1:0] = ((st_mix & CNT_B_SAT) != '0) ? DRV_NONE :
                        (dir[0] ? DRV_POS : DRV_NEG);

      // Count up each counter that has not yet saturated.
      assign st_new = st_mix + ((~st_mix >> 2) & STEP_MASK);

      assign video_codes[4*(PAIRS-1-p) +: 4] = nib;
      assign video_word[PAIR_W*p +: PAIR_W]  = st_new;
   end

   // Mode select; only video mode touches the state store.
   always_comb begin
      drive.next_word = video_word;
      drive.state_we  = 1'b0;
      unique case (cfg.mode)
         MODE_IMAGE: begin
            {drive.first_drive, drive.second_drive} = image_codes;
         end
         MODE_VIDEO: begin
            {drive.first_drive, drive.second_drive} = video_codes;
            drive.state_we = 1'b1;
         end
         default: begin
            {drive.first_drive, drive.second_drive} = '0;
         end
      endcase
   end

endmodule
